FILE: hw/rtl/bbd_pkg.sv
// shared types and constants for the bayer bilinear demosaic block
package bbd_pkg;

	localparam int COORD_BITS  = 13;
	localparam int SIZE_BITS   = 14;
	localparam int MIN_SIZE    = 3;
	localparam int MAX_HEIGHT  = 8192;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
	localparam int QCOUNT_BITS = $clog2(QUEUE_DEPTH + 1);

	// register indexes on the configuration port
	localparam logic CFG_WIDTH  = 1'b0;
	localparam logic CFG_HEIGHT = 1'b1;

	// bayer site of an interior pixel (grbg mosaic)
	localparam logic [1:0] SITE_RED     = 2'd0;
	localparam logic [1:0] SITE_GREEN_R = 2'd1;
	localparam logic [1:0] SITE_GREEN_B = 2'd2;
	localparam logic [1:0] SITE_BLUE    = 2'd3;

	typedef struct packed {
		logic [1:0]            site;
		logic [COORD_BITS-1:0] pixel_column;
		logic [COORD_BITS-1:0] pixel_row;
		logic                  frame_end;
	} meta_t;

endpackage

FILE: hw/rtl/bbd_front.sv
// front end: raster counters, line store, window and site classification
module bbd_front #(
	parameter int MAX_WIDTH   = 8192,
	parameter int SAMPLE_BITS = 10
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [9:0]                          raw_sample,
	input  logic [bbd_pkg::SIZE_BITS-1:0]       image_width,
	input  logic [bbd_pkg::SIZE_BITS-1:0]       image_height,
	input  logic [bbd_pkg::QCOUNT_BITS-1:0]     q_count,
	output logic                                push,
	output bbd_pkg::meta_t                      push_meta,
	output logic [9*SAMPLE_BITS-1:0]            push_win
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int SW = SAMPLE_BITS;

	logic [CW-1:0]                     col_q;
	logic [bbd_pkg::COORD_BITS-1:0]    row_q;
	logic [14:0]                       w_use;
	logic [13:0]                       h_use;
	logic [14:0]                       col_inc;
	logic [13:0]                       row_inc;
	logic                              accept;
	logic                              emit;
	logic [CW-1:0]                     pc_full;
	logic [bbd_pkg::COORD_BITS-1:0]    pr_full;
	bbd_pkg::meta_t                    meta;

	logic [2*SW-1:0]                   mem [MAX_WIDTH];
	logic [2*SW-1:0]                   rd_s1;
	logic                              valid_s1;
	logic [SW-1:0]                     s_s1;
	logic [CW-1:0]                     addr_s1;
	logic                              emit_s1;
	bbd_pkg::meta_t                    meta_s1;
	logic [3*SW-1:0]                   col_a_q;
	logic [3*SW-1:0]                   col_b_q;
	logic [3*SW-1:0]                   new_col;

	// size limits in use
	always_comb begin
		if (image_width < 14'(bbd_pkg::MIN_SIZE)) begin
			w_use = 15'(bbd_pkg::MIN_SIZE);
		end else if ({1'b0, image_width} > 15'(MAX_WIDTH)) begin
			w_use = 15'(MAX_WIDTH);
		end else begin
			w_use = {1'b0, image_width};
		end
		if (image_height < 14'(bbd_pkg::MIN_SIZE)) begin
			h_use = 14'(bbd_pkg::MIN_SIZE);
		end else if (image_height > 14'(bbd_pkg::MAX_HEIGHT)) begin
			h_use = 14'(bbd_pkg::MAX_HEIGHT);
		end else begin
			h_use = image_height;
		end
	end

	assign accept  = in_valid && in_ready;
	assign in_ready = ((4'(q_count) + 4'(valid_s1 && emit_s1)) < 4'(bbd_pkg::QUEUE_DEPTH));
	assign col_inc = 15'(col_q) + 15'd1;
	assign row_inc = {1'b0, row_q} + 14'd1;
	assign emit    = (col_q >= CW'(2)) && (row_q >= 13'd2);
	assign pc_full = col_q - CW'(1);
	assign pr_full = row_q - 13'd1;

	// classify the pixel one up and one left of the arriving sample
	always_comb begin
		meta.pixel_column = bbd_pkg::COORD_BITS'(pc_full);
		meta.pixel_row    = pr_full;
		meta.frame_end    = (15'(col_q) == w_use - 15'd1) && ({1'b0, row_q} == h_use - 14'd1);
		case ({pr_full[0], pc_full[0]})
			2'b01:   meta.site = bbd_pkg::SITE_RED;
			2'b00:   meta.site = bbd_pkg::SITE_GREEN_R;
			2'b11:   meta.site = bbd_pkg::SITE_GREEN_B;
			default: meta.site = bbd_pkg::SITE_BLUE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			if (accept) begin
				if (col_inc >= w_use) begin
					col_q <= '0;
					if (row_inc >= h_use) begin
						row_q <= '0;
					end else begin
						row_q <= row_inc[bbd_pkg::COORD_BITS-1:0];
					end
				end else begin
					col_q <= col_inc[CW-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			s_s1    <= SW'(raw_sample);
			addr_s1 <= col_q;
			emit_s1 <= emit;
			meta_s1 <= meta;
		end
	end

	// line store: one entry holds {row two above, row one above}
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_s1 <= mem[col_q];
		end
		if (valid_s1) begin
			mem[addr_s1] <= {rd_s1[SW-1:0], s_s1};
		end
	end

	assign new_col = {rd_s1, s_s1};

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			col_a_q <= col_b_q;
			col_b_q <= new_col;
		end
	end

	assign push      = valid_s1 && emit_s1;
	assign push_meta = meta_s1;
	assign push_win  = {col_a_q, col_b_q, new_col};

endmodule

FILE: hw/rtl/bbd_queue.sv
// short job queue between front and back
module bbd_queue #(
	parameter int WIDTH = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            push,
	input  logic [WIDTH-1:0]                push_data,
	input  logic                            pop,
	output logic                            q_valid,
	output logic [WIDTH-1:0]                q_data,
	output logic [bbd_pkg::QCOUNT_BITS-1:0] q_count
);

	logic [WIDTH-1:0]                 slot_q [bbd_pkg::QUEUE_DEPTH];
	logic [bbd_pkg::QPTR_BITS-1:0]    wr_ptr_q;
	logic [bbd_pkg::QPTR_BITS-1:0]    rd_ptr_q;
	logic [bbd_pkg::QCOUNT_BITS-1:0]  count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	assign q_valid = (count_q != '0);
	assign q_data  = slot_q[rd_ptr_q];
	assign q_count = count_q;

endmodule

FILE: hw/rtl/bbd_back.sv
// back end: channel sums by site and the output register
module bbd_back #(
	parameter int SAMPLE_BITS = 10
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            q_valid,
	input  bbd_pkg::meta_t                  q_meta,
	input  logic [9*SAMPLE_BITS-1:0]        q_win,
	output logic                            pop,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [15:0]                     red,
	output logic [15:0]                     green,
	output logic [15:0]                     blue,
	output logic [bbd_pkg::COORD_BITS-1:0]  pixel_column,
	output logic [bbd_pkg::COORD_BITS-1:0]  pixel_row,
	output logic                            frame_end
);

	localparam int SW   = SAMPLE_BITS;
	localparam int SUMW = SAMPLE_BITS + 2;

	logic [SW-1:0]      a_u, a_m, a_l, b_u, b_m, b_l, n_u, n_m, n_l;
	logic [SUMW-1:0]    ctr4, ns2, we2, nswe, diag;
	logic [SUMW-1:0]    rs, gs, bs;
	logic [SUMW+19:0]   r_wide, g_wide, b_wide;
	logic               out_valid_q;

	// window columns, oldest first, each {upper, middle, lower}
	assign a_u = q_win[9*SW-1 -: SW];
	assign a_m = q_win[8*SW-1 -: SW];
	assign a_l = q_win[7*SW-1 -: SW];
	assign b_u = q_win[6*SW-1 -: SW];
	assign b_m = q_win[5*SW-1 -: SW];
	assign b_l = q_win[4*SW-1 -: SW];
	assign n_u = q_win[3*SW-1 -: SW];
	assign n_m = q_win[2*SW-1 -: SW];
	assign n_l = q_win[SW-1 -: SW];

	assign ctr4  = {b_m, 2'b00};
	assign ns2   = {SUMW'(b_u) + SUMW'(b_l)} << 1;
	assign we2   = {SUMW'(a_m) + SUMW'(n_m)} << 1;
	assign nswe  = SUMW'(b_u) + SUMW'(b_l) + SUMW'(a_m) + SUMW'(n_m);
	assign diag  = SUMW'(a_u) + SUMW'(n_u) + SUMW'(a_l) + SUMW'(n_l);

	always_comb begin
		case (q_meta.site)
			bbd_pkg::SITE_RED: begin
				rs = ctr4;  gs = nswe;  bs = diag;
			end
			bbd_pkg::SITE_GREEN_R: begin
				rs = we2;   gs = ctr4;  bs = ns2;
			end
			bbd_pkg::SITE_GREEN_B: begin
				rs = ns2;   gs = ctr4;  bs = we2;
			end
			default: begin
				rs = diag;  gs = nswe;  bs = ctr4;
			end
		endcase
	end

	assign r_wide = {16'd0, rs, 4'd0};
	assign g_wide = {16'd0, gs, 4'd0};
	assign b_wide = {16'd0, bs, 4'd0};

	assign pop = q_valid && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			red          <= r_wide[15:0];
			green        <= g_wide[15:0];
			blue         <= b_wide[15:0];
			pixel_column <= q_meta.pixel_column;
			pixel_row    <= q_meta.pixel_row;
			frame_end    <= q_meta.frame_end;
		end
	end

	assign out_valid = out_valid_q;

endmodule

FILE: hw/rtl/bayer_bilinear_demosaic_core.sv
// top level of the bayer bilinear demosaic block
//
//  channel   signals                                  direction
//  in        in_valid in_ready raw_sample              sample stream in
//  out       out_valid out_ready red green blue
//            pixel_column pixel_row frame_end           rgb result out
//  cfg       cfg_valid cfg_ready cfg_index cfg_data     register write
//
//  one sample transfer per cycle while in_ready is high; out_valid rises after the
//  sample transfer that completes a window, through the line store read register,
//  the job queue and the output register
//  the line store has no clearing pass and rows zero and one produce no result
//  the job queue holds four results; in_ready drops when queued jobs plus the job
//  in the read stage reach four
//  reset restores width 7728, height 5368 and clears counters and queue
module bayer_bilinear_demosaic_core #(
	parameter int MAX_WIDTH   = 8192,
	parameter int SAMPLE_BITS = 10
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [9:0]                      raw_sample,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [15:0]                     red,
	output logic [15:0]                     green,
	output logic [15:0]                     blue,
	output logic [bbd_pkg::COORD_BITS-1:0]  pixel_column,
	output logic [bbd_pkg::COORD_BITS-1:0]  pixel_row,
	output logic                            frame_end,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic                            cfg_index,
	input  logic [bbd_pkg::SIZE_BITS-1:0]   cfg_data
);

	localparam int MW = $bits(bbd_pkg::meta_t);
	localparam int WW = 9 * SAMPLE_BITS;

	logic [bbd_pkg::SIZE_BITS-1:0]    image_width_q;
	logic [bbd_pkg::SIZE_BITS-1:0]    image_height_q;
	logic [bbd_pkg::QCOUNT_BITS-1:0]  q_count;
	logic                             push;
	bbd_pkg::meta_t                   push_meta;
	logic [WW-1:0]                    push_win;
	logic                             pop;
	logic                             q_valid;
	logic [MW+WW-1:0]                 q_data;
	bbd_pkg::meta_t                   q_meta;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= 14'd7728;
			image_height_q <= 14'd5368;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				bbd_pkg::CFG_WIDTH:  image_width_q  <= cfg_data;
				bbd_pkg::CFG_HEIGHT: image_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	bbd_front #(
		.MAX_WIDTH   (MAX_WIDTH),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.raw_sample   (raw_sample),
		.image_width  (image_width_q),
		.image_height (image_height_q),
		.q_count      (q_count),
		.push         (push),
		.push_meta    (push_meta),
		.push_win     (push_win)
	);

	bbd_queue #(
		.WIDTH (MW + WW)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data ({push_meta, push_win}),
		.pop       (pop),
		.q_valid   (q_valid),
		.q_data    (q_data),
		.q_count   (q_count)
	);

	assign q_meta = q_data[MW+WW-1:WW];

	bbd_back #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_meta       (q_meta),
		.q_win        (q_data[WW-1:0]),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.red          (red),
		.green        (green),
		.blue         (blue),
		.pixel_column (pixel_column),
		.pixel_row    (pixel_row),
		.frame_end    (frame_end)
	);

	// queue never takes a job while full
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |-> (q_count < bbd_pkg::QCOUNT_BITS'(bbd_pkg::QUEUE_DEPTH)))
		else $error("job queue overflow");

	// back end only pops a present job
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> q_valid)
		else $error("job queue underflow");

	// input stalls only with jobs waiting
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (q_count != '0))
		else $error("input stalled with empty queue");

	// a popped job appears at the output on the next cycle
	a_pop_shows: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> out_valid)
		else $error("popped job not presented");

endmodule

FILE: verif/testbench.sv
// self-checking testbench for bayer_bilinear_demosaic_core: predicts and compares every rgb result
module testbench;

	localparam int LINE_MAX      = 8192;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int SETTLE_CYCLES = 8;
	localparam int GAP_MAX       = 11;
	localparam int RANDOM_ITEMS  = 1330;

	typedef struct packed {
		logic [15:0]                    red;
		logic [15:0]                    green;
		logic [15:0]                    blue;
		logic [bbd_pkg::COORD_BITS-1:0] pixel_column;
		logic [bbd_pkg::COORD_BITS-1:0] pixel_row;
		logic                           frame_end;
	} rgb_pixel_t;

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           in_valid;
	logic                           in_ready;
	logic [9:0]                     raw_sample;
	logic                           out_valid;
	logic                           out_ready;
	logic [15:0]                    red;
	logic [15:0]                    green;
	logic [15:0]                    blue;
	logic [bbd_pkg::COORD_BITS-1:0] pixel_column;
	logic [bbd_pkg::COORD_BITS-1:0] pixel_row;
	logic                           frame_end;
	logic                           cfg_valid;
	logic                           cfg_ready;
	logic                           cfg_index;
	logic [bbd_pkg::SIZE_BITS-1:0]  cfg_data;

	// predictor state
	rgb_pixel_t                    rgb_pending[$];
	logic [9:0]                    row_two_up [LINE_MAX];
	logic [9:0]                    row_one_up [LINE_MAX];
	logic [9:0]                    win [3][3] = '{default: 10'd0};
	int unsigned                   col_pos;
	int unsigned                   row_pos;
	logic [bbd_pkg::SIZE_BITS-1:0] width_reg;
	logic [bbd_pkg::SIZE_BITS-1:0] height_reg;

	int unsigned tx_gap_max;
	int unsigned rx_gap_max;
	int unsigned rx_hold;
	int unsigned error_count;
	int unsigned sample_count;
	int unsigned pixel_count;
	int unsigned frame_count;
	int unsigned stall_cycles;
	int unsigned cycle_count;

	bayer_bilinear_demosaic_core #(
		.MAX_WIDTH(LINE_MAX),
		.SAMPLE_BITS(10)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.raw_sample(raw_sample),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.red(red),
		.green(green),
		.blue(blue),
		.pixel_column(pixel_column),
		.pixel_row(pixel_row),
		.frame_end(frame_end),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic int unsigned fit_size(input int unsigned v, input int unsigned hi);
		if (v < bbd_pkg::MIN_SIZE)
			return bbd_pkg::MIN_SIZE;
		if (v > hi)
			return hi;
		return v;
	endfunction

	function automatic logic [9:0] pick_sample();
		case ($urandom_range(7, 0))
			0: return 10'h000;
			1: return 10'h3ff;
			default: return 10'($urandom_range(1023, 0));
		endcase
	endfunction

	function automatic void demosaic_predict(input logic [9:0] smp);
		int unsigned w, h, k, ctr, ns, we, dg, rs, gs, bs;
		logic        pr_odd, pc_odd;
		logic [1:0]  site;
		rgb_pixel_t  px;
		w = fit_size(width_reg, LINE_MAX);
		h = fit_size(height_reg, bbd_pkg::MAX_HEIGHT);
		for (k = 0; k < 3; k++) begin
			win[k][0] = win[k][1];
			win[k][1] = win[k][2];
		end
		win[0][2] = row_two_up[col_pos];
		win[1][2] = row_one_up[col_pos];
		win[2][2] = smp;
		row_two_up[col_pos] = row_one_up[col_pos];
		row_one_up[col_pos] = smp;
		sample_count++;
		if (col_pos >= 2 && row_pos >= 2) begin
			ctr = win[1][1];
			ns = win[0][1] + win[2][1];
			we = win[1][0] + win[1][2];
			dg = win[0][0] + win[0][2] + win[2][0] + win[2][2];
			pr_odd = (row_pos - 1) % 2;
			pc_odd = (col_pos - 1) % 2;
			if (!pr_odd)
				site = pc_odd ? bbd_pkg::SITE_RED : bbd_pkg::SITE_GREEN_R;
			else
				site = pc_odd ? bbd_pkg::SITE_GREEN_B : bbd_pkg::SITE_BLUE;
			case (site)
				bbd_pkg::SITE_RED: begin
					rs = 4 * ctr;
					gs = ns + we;
					bs = dg;
				end
				bbd_pkg::SITE_GREEN_R: begin
					rs = 2 * we;
					gs = 4 * ctr;
					bs = 2 * ns;
				end
				bbd_pkg::SITE_GREEN_B: begin
					rs = 2 * ns;
					gs = 4 * ctr;
					bs = 2 * we;
				end
				default: begin
					rs = dg;
					gs = ns + we;
					bs = 4 * ctr;
				end
			endcase
			px.red = 16'(rs << 4);
			px.green = 16'(gs << 4);
			px.blue = 16'(bs << 4);
			px.pixel_column = bbd_pkg::COORD_BITS'(col_pos - 1);
			px.pixel_row = bbd_pkg::COORD_BITS'(row_pos - 1);
			px.frame_end = (col_pos == w - 1) && (row_pos == h - 1);
			rgb_pending.push_back(px);
		end
		col_pos++;
		if (col_pos >= w) begin
			col_pos = 0;
			row_pos++;
			if (row_pos >= h)
				row_pos = 0;
		end
	endfunction

	function automatic void compare_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			error_count++;
		end
	endfunction

	always @(posedge clk) begin : result_check
		rgb_pixel_t want;
		if (out_valid === 1'b1 && out_ready === 1'b1) begin
			if (rgb_pending.size() == 0) begin
				$error("rgb transfer at column %0d row %0d with no pixel expected",
					pixel_column, pixel_row);
				error_count++;
			end else begin
				want = rgb_pending.pop_front();
				compare_field("red", want.red, red);
				compare_field("green", want.green, green);
				compare_field("blue", want.blue, blue);
				compare_field("pixel_column", want.pixel_column, pixel_column);
				compare_field("pixel_row", want.pixel_row, pixel_row);
				compare_field("frame_end", want.frame_end, frame_end);
				pixel_count++;
				if (want.frame_end)
					frame_count++;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (in_valid === 1'b1 && in_ready === 1'b0)
			stall_cycles++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("run stopped after %0d cycles, %0d pixels still pending",
				CYCLE_LIMIT, rgb_pending.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// result side: random ready gaps, plus one long hold on request
	initial begin : receiver
		int unsigned gap;
		out_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (rx_hold != 0) begin
				gap = rx_hold;
				rx_hold = 0;
			end else begin
				gap = (rx_gap_max != 0) ? $urandom_range(rx_gap_max, 0) : 0;
			end
			if (gap != 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!(out_valid === 1'b1 && out_ready === 1'b1));
		end
	end

	task automatic push_sample(input logic [9:0] smp);
		int unsigned gap;
		gap = (tx_gap_max != 0) ? $urandom_range(tx_gap_max, 0) : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		raw_sample <= smp;
		do @(posedge clk); while (in_ready !== 1'b1);
		demosaic_predict(smp);
	endtask

	task automatic drain_pixels();
		in_valid <= 1'b0;
		while (rgb_pending.size() != 0)
			@(posedge clk);
		// a sample that completes no window may still be in flight
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(input logic idx, input int unsigned val, input bit close);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= bbd_pkg::SIZE_BITS'(val);
		do @(posedge clk); while (cfg_ready !== 1'b1);
		if (idx == bbd_pkg::CFG_WIDTH)
			width_reg = bbd_pkg::SIZE_BITS'(val);
		else
			height_reg = bbd_pkg::SIZE_BITS'(val);
		if (close)
			cfg_valid <= 1'b0;
	endtask

	task automatic set_frame(input int unsigned w, input int unsigned h);
		drain_pixels();
		cfg_write(bbd_pkg::CFG_WIDTH, w, 1'b0);
		cfg_write(bbd_pkg::CFG_HEIGHT, h, 1'b1);
	endtask

	task automatic send_frames(input int unsigned n);
		repeat (n * fit_size(width_reg, LINE_MAX) * fit_size(height_reg, bbd_pkg::MAX_HEIGHT))
			push_sample(pick_sample());
	endtask

	task automatic finish_frame();
		do push_sample(pick_sample()); while (col_pos != 0 || row_pos != 0);
	endtask

	task automatic test_sites_and_extremes();
		int k;
		tx_gap_max = GAP_MAX;
		rx_gap_max = GAP_MAX;
		// odd columns full scale, even columns zero: all four sites appear
		set_frame(4, 4);
		for (k = 0; k < 16; k++)
			push_sample((k % 2) ? 10'h3ff : 10'h000);
		set_frame(3, 3);
		repeat (9) push_sample(10'h3ff);
	endtask

	task automatic test_height_change();
		tx_gap_max = GAP_MAX;
		rx_gap_max = GAP_MAX;
		// shrink below the current row: row runs out, then wraps
		set_frame(5, 10);
		repeat (5 * 6) push_sample(pick_sample());
		drain_pixels();
		cfg_write(bbd_pkg::CFG_HEIGHT, 4, 1'b1);
		finish_frame();
		// grow before any window completes
		set_frame(5, 3);
		repeat (5 * 2) push_sample(pick_sample());
		drain_pixels();
		cfg_write(bbd_pkg::CFG_HEIGHT, 6, 1'b1);
		finish_frame();
	endtask

	task automatic test_width_change();
		tx_gap_max = GAP_MAX;
		rx_gap_max = 0;
		// column counter beyond the new width wraps on the next advance
		set_frame(8, 8);
		repeat (8 * 3 + 5) push_sample(pick_sample());
		drain_pixels();
		cfg_write(bbd_pkg::CFG_WIDTH, 4, 1'b1);
		finish_frame();
	endtask

	task automatic test_backpressure();
		tx_gap_max = 0;
		rx_gap_max = 0;
		set_frame(6, 6);
		rx_hold = 150;
		send_frames(3);
	endtask

	task automatic test_random_frames();
		int unsigned first, w, h;
		first = sample_count;
		while (sample_count - first < RANDOM_ITEMS) begin
			tx_gap_max = $urandom_range(1, 0) ? GAP_MAX : 0;
			rx_gap_max = $urandom_range(1, 0) ? GAP_MAX : 0;
			w = ($urandom_range(7, 0) == 0) ? $urandom_range(2, 0) : $urandom_range(12, 3);
			h = ($urandom_range(7, 0) == 0) ? $urandom_range(2, 0) : $urandom_range(9, 3);
			set_frame(w, h);
			send_frames($urandom_range(2, 1));
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		raw_sample <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= bbd_pkg::CFG_WIDTH;
		cfg_data <= '0;
		width_reg = bbd_pkg::SIZE_BITS'(7728);
		height_reg = bbd_pkg::SIZE_BITS'(5368);
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_sites_and_extremes();
		test_height_change();
		test_width_change();
		test_backpressure();
		test_random_frames();
		drain_pixels();
		$display("sent %0d samples, checked %0d rgb pixels over %0d complete frames",
			sample_count, pixel_count, frame_count);
		$display("small frames with clamped and mid-frame sizes, %0d cycles of input stall",
			stall_cycles);
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

FILE: filelist.f
hw/rtl/bbd_pkg.sv
hw/rtl/bbd_front.sv
hw/rtl/bbd_queue.sv
hw/rtl/bbd_back.sv
hw/rtl/bayer_bilinear_demosaic_core.sv
verif/testbench.sv
